// ===== hw/rtl/hrx_pkg.sv =====
// Shared types, constants and helpers of the HTTP request header extractor.
// No dependencies; used by hrx_parser, hrx_out_queue and the top level.
package hrx_pkg;

	// keywords matched against the last four bytes
	localparam logic [31:0] KW_GET   = 32'h47455420;
	localparam logic [31:0] KW_POST  = 32'h504F5354;
	localparam logic [31:0] KW_CONT  = 32'h436F6E74;
	localparam logic [31:0] KW_HOST  = 32'h486F7374;
	localparam logic [31:0] KW_REFE  = 32'h52656665;
	localparam logic [31:0] KW_USER  = 32'h55736572;
	localparam logic [31:0] TY_MULT  = 32'h6D756C74;
	localparam logic [31:0] TY_APPL  = 32'h6170706C;
	localparam logic [31:0] TAIL_HTM = 32'h2E68746D;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_LOW_H = 8'h68;
	localparam logic [7:0] CH_LOW_T = 8'h74;

	// result kinds
	localparam logic [2:0] KIND_PATH    = 3'd0;
	localparam logic [2:0] KIND_HOST    = 3'd1;
	localparam logic [2:0] KIND_REFERER = 3'd2;
	localparam logic [2:0] KIND_AGENT   = 3'd3;
	localparam logic [2:0] KIND_SUMMARY = 3'd4;

	// content type classes
	localparam logic [1:0] CT_NONE  = 2'd0;
	localparam logic [1:0] CT_MULTI = 2'd1;
	localparam logic [1:0] CT_APPL  = 2'd2;
	localparam logic [1:0] CT_OTHER = 2'd3;

	// content length sub-states held in the skip counter
	localparam logic [3:0] LSK_START  = 4'd0;
	localparam logic [3:0] LSK_DIGITS = 4'd1;
	localparam logic [3:0] LSK_NEG    = 4'd2;
	localparam logic [3:0] LSK_DONE   = 4'd3;

	// configuration register indexes
	localparam logic [1:0] REG_PATH_LIMIT  = 2'd0;
	localparam logic [1:0] REG_HOST_LIMIT  = 2'd1;
	localparam logic [1:0] REG_AGENT_LIMIT = 2'd2;

	localparam int MAX_FIELD_DEF = 256;

	typedef enum logic [15:0] {
		PH_SCAN      = 16'h0001,
		PH_SLASH     = 16'h0002,
		PH_PATH      = 16'h0004,
		PH_CONT      = 16'h0008,
		PH_TYPE_SP   = 16'h0010,
		PH_TYPE_VAL  = 16'h0020,
		PH_LEN_SP    = 16'h0040,
		PH_LEN_VAL   = 16'h0080,
		PH_HOST_SP   = 16'h0100,
		PH_HOST_VAL  = 16'h0200,
		PH_REF_SP    = 16'h0400,
		PH_REF_PROBE = 16'h0800,
		PH_REF_VAL   = 16'h1000,
		PH_UA_SP     = 16'h2000,
		PH_UA_VAL    = 16'h4000,
		PH_DEAD      = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [2:0]  field_kind;
		logic [7:0]  position;
		logic [7:0]  char_value;
		logic [1:0]  content_type;
		logic [31:0] content_length;
		logic        is_html;
		logic        has_query;
		logic [7:0]  query_pos;
		logic [3:0]  seen_flags;
		logic        ok;
		logic        summary_last;
	} result_t;

	typedef struct packed {
		phase_t phase;
		logic   failed;
	} parse_status_t;

	// class of a Content-Type value from its first bytes
	function automatic logic [1:0] type_class_of(logic [31:0] prefix, logic [7:0] count);
		logic [31:0] p;
		begin
			case (count)
				8'd0: p = '0;
				8'd1: p = {prefix[7:0], 24'h0};
				8'd2: p = {prefix[15:0], 16'h0};
				8'd3: p = {prefix[23:0], 8'h0};
				default: p = prefix;
			endcase
			if (p == TY_MULT) type_class_of = CT_MULTI;
			else if (p == TY_APPL) type_class_of = CT_APPL;
			else type_class_of = CT_OTHER;
		end
	endfunction

	// html bit at the end of a GET path
	function automatic logic html_of(logic q_valid, logic [7:0] q_idx, logic [7:0] fidx,
			logic [31:0] tail);
		logic [7:0] vlen;
		begin
			vlen = q_valid ? q_idx : fidx;
			html_of = (vlen > 8'd4) && (tail == TAIL_HTM);
		end
	endfunction

	function automatic logic ends_plain(logic [7:0] b);
		ends_plain = (b == CH_CR) || (b == CH_NUL) || (b == CH_SP);
	endfunction

endpackage

// ===== hw/rtl/hrx_parser.sv =====
// Per-byte header parser: keyword window, phase register and field counters.
// Depends on hrx_pkg; emits up to one field byte and one summary per beat.
module hrx_parser import hrx_pkg::*; #(
	parameter int MAX_FIELD = MAX_FIELD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    byte_value,
	input  logic          last_byte,
	input  logic [7:0]    path_limit,
	input  logic [7:0]    host_limit,
	input  logic [7:0]    agent_limit,
	output logic          byte_valid,
	output result_t       byte_res,
	output logic          sum_valid,
	output result_t       sum_res,
	output parse_status_t status
);

	localparam int CAP_INT = (MAX_FIELD - 1 > 255) ? 255 : MAX_FIELD - 1;
	localparam logic [7:0] CAP = 8'(CAP_INT);

	typedef struct packed {
		phase_t      phase;
		logic [31:0] win;
		logic [7:0]  fidx;
		logic [3:0]  skip;
		logic [31:0] len;
		logic [31:0] tprefix;
		logic [1:0]  tclass;
		logic [4:0]  found;
		logic [31:0] tail;
		logic        q_valid;
		logic [7:0]  q_idx;
		logic        failed;
		logic        is_get;
		logic        html;
	} st_t;

	st_t st_q, nx, fin;
	logic [7:0]  path_cap, host_cap, agent_cap, val_cap;
	logic [31:0] w;
	logic        dig;
	logic [3:0]  d;
	logic [35:0] len_mac;

	assign path_cap  = (path_limit > CAP) ? CAP : path_limit;
	assign host_cap  = (host_limit > CAP) ? CAP : host_limit;
	assign agent_cap = (agent_limit > CAP) ? CAP : agent_limit;
	assign w   = {st_q.win[23:0], byte_value};
	assign dig = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
	assign d   = dig ? 4'(byte_value - CH_ZERO) : 4'd0;
	// ten times the value plus the digit, overflow kept
	assign len_mac = {st_q.len, 3'b000} + {3'b000, st_q.len, 1'b0} + {32'h0, d};

	// next state and field byte for this beat
	always_comb begin
		nx = st_q;
		byte_valid = 1'b0;
		byte_res = '0;
		val_cap = agent_cap;

		// a non-space byte after a value's leading spaces starts the value itself
		case (st_q.phase)
			PH_TYPE_SP: if (byte_value != CH_SP) begin
				nx.phase = PH_TYPE_VAL;
				nx.fidx = '0;
				nx.tprefix = '0;
			end
			PH_LEN_SP: if (byte_value != CH_SP) begin
				nx.phase = PH_LEN_VAL;
				nx.skip = LSK_START;
			end
			PH_HOST_SP: if (st_q.skip == 4'd0 && byte_value != CH_SP) begin
				nx.phase = PH_HOST_VAL;
				nx.fidx = '0;
			end
			PH_UA_SP: if (st_q.skip == 4'd0 && byte_value != CH_SP) begin
				nx.phase = PH_UA_VAL;
				nx.fidx = '0;
			end
			default: ;
		endcase

		case (nx.phase)
			PH_SCAN: begin
				nx.win = w;
				if (w == KW_GET || w == KW_POST) begin
					nx.phase = PH_SLASH;
					nx.is_get = (w == KW_GET);
					nx.skip = (w == KW_GET) ? 4'd0 : 4'd1;
				end else if (w == KW_CONT) begin
					nx.phase = PH_CONT;
					nx.fidx = 8'd4;
				end else if (w == KW_HOST) begin
					nx.phase = PH_HOST_SP;
					nx.skip = 4'd1;
					nx.found[1] = 1'b1;
				end else if (w == KW_REFE) begin
					nx.phase = PH_REF_SP;
					nx.skip = 4'd4;
				end else if (w == KW_USER && !st_q.found[3]) begin
					nx.phase = PH_UA_SP;
					nx.skip = 4'd7;
					nx.found[3] = 1'b1;
				end
			end
			PH_SLASH: begin
				if (st_q.skip != 4'd0) begin
					nx.skip = st_q.skip - 4'd1;
				end else if (byte_value != CH_SLASH) begin
					nx.failed = 1'b1;
					nx.phase = PH_DEAD;
				end else begin
					nx.phase = PH_PATH;
					nx.fidx = '0;
					if (st_q.is_get) begin
						nx.found[0] = 1'b1;
						nx.q_valid = 1'b0;
						nx.tail = '0;
						nx.html = 1'b0;
					end
				end
			end
			PH_PATH: begin
				if (ends_plain(byte_value)) begin
					if (st_q.is_get)
						nx.html = html_of(st_q.q_valid, st_q.q_idx, st_q.fidx, st_q.tail);
					nx.phase = PH_SCAN;
					nx.win = '0;
				end else if (st_q.fidx < path_cap) begin
					byte_valid = 1'b1;
					byte_res.field_kind = KIND_PATH;
					byte_res.position = st_q.fidx;
					byte_res.char_value = byte_value;
					if (st_q.is_get && !st_q.q_valid) begin
						if (byte_value == CH_QUEST) begin
							nx.q_valid = 1'b1;
							nx.q_idx = st_q.fidx;
						end else begin
							nx.tail = {st_q.tail[23:0], byte_value};
						end
					end
					nx.fidx = st_q.fidx + 8'd1;
				end
			end
			PH_CONT: begin
				if (st_q.fidx < 8'd12) begin
					nx.fidx = st_q.fidx + 8'd1;
				end else if (st_q.fidx == 8'd12) begin
					if (byte_value == CH_COLON) begin
						nx.phase = PH_TYPE_SP;
						nx.skip = '0;
					end else if (byte_value == CH_LOW_T) begin
						nx.fidx = 8'd13;
					end else begin
						nx.phase = PH_SCAN;
						nx.win = '0;
					end
				end else if (st_q.fidx == 8'd13) begin
					if (byte_value == CH_LOW_H) begin
						nx.fidx = 8'd14;
					end else begin
						nx.phase = PH_SCAN;
						nx.win = {24'h0, byte_value};
					end
				end else begin
					if (byte_value == CH_COLON) begin
						nx.phase = PH_LEN_SP;
						nx.len = '0;
						nx.skip = '0;
					end else begin
						nx.phase = PH_SCAN;
						nx.win = {24'h0, byte_value};
					end
				end
			end
			PH_TYPE_VAL: begin
				if (ends_plain(byte_value)) begin
					if (!nx.found[4]) begin
						nx.tclass = type_class_of(nx.tprefix, nx.fidx);
						nx.found[4] = 1'b1;
					end
					nx.phase = PH_SCAN;
					nx.win = '0;
				end else if (nx.fidx < 8'd4) begin
					nx.tprefix = {nx.tprefix[23:0], byte_value};
					nx.fidx = nx.fidx + 8'd1;
				end
			end
			PH_LEN_VAL: begin
				if (ends_plain(byte_value)) begin
					nx.phase = PH_SCAN;
					nx.win = '0;
				end else begin
					case (nx.skip)
						LSK_START: begin
							if (byte_value == CH_TAB || byte_value == CH_LF
									|| byte_value == CH_VT || byte_value == CH_FF) begin
								nx.skip = LSK_START;
							end else if (byte_value == CH_PLUS) begin
								nx.skip = LSK_DIGITS;
							end else if (byte_value == CH_MINUS) begin
								nx.skip = LSK_NEG;
							end else if (dig) begin
								nx.len = {28'h0, d};
								nx.skip = LSK_DIGITS;
							end else begin
								nx.skip = LSK_DONE;
							end
						end
						LSK_DIGITS: begin
							if (!dig) nx.skip = LSK_DONE;
							else if (len_mac[35:32] != 4'd0) nx.len = '1;
							else nx.len = len_mac[31:0];
						end
						LSK_NEG: if (!dig) nx.skip = LSK_DONE;
						default: ;
					endcase
				end
			end
			PH_HOST_SP, PH_UA_SP: begin
				if (st_q.skip != 4'd0) nx.skip = st_q.skip - 4'd1;
			end
			PH_HOST_VAL, PH_UA_VAL: begin
				val_cap = (nx.phase == PH_HOST_VAL) ? host_cap : agent_cap;
				if (byte_value == CH_CR || byte_value == CH_NUL) begin
					nx.phase = PH_SCAN;
					nx.win = '0;
				end else if (nx.fidx < val_cap) begin
					byte_valid = 1'b1;
					byte_res.field_kind = (nx.phase == PH_HOST_VAL) ? KIND_HOST : KIND_AGENT;
					byte_res.position = nx.fidx;
					byte_res.char_value = byte_value;
					nx.fidx = nx.fidx + 8'd1;
				end
			end
			PH_REF_SP: begin
				if (st_q.skip != 4'd0) begin
					nx.skip = st_q.skip - 4'd1;
				end else if (byte_value != CH_SP) begin
					nx.phase = PH_REF_PROBE;
					nx.fidx = 8'd1;
				end
			end
			PH_REF_PROBE: begin
				if ((st_q.fidx == 8'd4 || st_q.fidx == 8'd5) && byte_value == CH_COLON) begin
					nx.phase = PH_REF_VAL;
					nx.skip = 4'd2;
					nx.fidx = '0;
					nx.found[2] = 1'b1;
				end else if (st_q.fidx >= 8'd5) begin
					nx.failed = 1'b1;
					nx.phase = PH_DEAD;
				end else begin
					nx.fidx = st_q.fidx + 8'd1;
				end
			end
			PH_REF_VAL: begin
				if (st_q.skip != 4'd0) begin
					nx.skip = st_q.skip - 4'd1;
				end else if (byte_value == CH_SLASH || byte_value == CH_CR
						|| byte_value == CH_NUL) begin
					nx.phase = PH_SCAN;
					nx.win = '0;
				end else if (st_q.fidx < host_cap) begin
					byte_valid = 1'b1;
					byte_res.field_kind = KIND_REFERER;
					byte_res.position = st_q.fidx;
					byte_res.char_value = byte_value;
					nx.fidx = st_q.fidx + 8'd1;
				end
			end
			default: ;
		endcase
	end

	// close any open field and build the summary
	always_comb begin
		fin = nx;
		if (nx.phase == PH_PATH && nx.is_get)
			fin.html = html_of(nx.q_valid, nx.q_idx, nx.fidx, nx.tail);
		if ((nx.phase == PH_TYPE_SP || nx.phase == PH_TYPE_VAL) && !nx.found[4]) begin
			fin.tclass = type_class_of(nx.tprefix,
				(nx.phase == PH_TYPE_SP) ? 8'd0 : nx.fidx);
			fin.found[4] = 1'b1;
		end
		sum_valid = last_byte;
		sum_res = '0;
		sum_res.field_kind = KIND_SUMMARY;
		sum_res.content_type = fin.tclass;
		sum_res.content_length = fin.len;
		sum_res.is_html = fin.html;
		sum_res.has_query = fin.q_valid;
		sum_res.query_pos = fin.q_valid ? fin.q_idx : 8'd0;
		sum_res.seen_flags = fin.found[3:0];
		sum_res.ok = !fin.failed;
		sum_res.summary_last = 1'b1;
	end

	// advance on each accepted beat; return to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			st_q.phase <= PH_SCAN;
		end else if (accept) begin
			if (last_byte) begin
				st_q <= '0;
				st_q.phase <= PH_SCAN;
			end else begin
				st_q <= nx;
			end
		end
	end

	assign status.phase  = st_q.phase;
	assign status.failed = st_q.failed;

endmodule

// ===== hw/rtl/hrx_out_queue.sv =====
// Four-entry result queue taking up to two results per cycle.
// Depends on hrx_pkg for result_t.
module hrx_out_queue import hrx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr0,
	input  result_t din0,
	input  logic    wr1,
	input  result_t din1,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t dout
);

	result_t     entry_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  count_q;
	logic        pop;
	logic [1:0]  wp1;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != 3'd0;
	assign dout      = entry_q[rp_q];
	// keep two free slots so a beat never blocks on its summary
	assign room      = count_q <= 3'd2;
	assign wp1       = wp_q + 2'(wr0);

	// write payload
	always_ff @(posedge clk) begin
		if (wr0) entry_q[wp_q] <= din0;
		if (wr1) entry_q[wp1] <= din1;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + 2'(wr0) + 2'(wr1);
			rp_q <= rp_q + 2'(pop);
			count_q <= count_q + 3'(wr0) + 3'(wr1) - 3'(pop);
		end
	end

endmodule

// ===== hw/rtl/http_request_header_extractor_top.sv =====
// Top level of the HTTP request header extractor: config registers,
// parser and result queue. Depends on hrx_pkg, hrx_parser, hrx_out_queue.
//
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, byte_value, last_byte | byte stream in
//  out     | out_valid/out_ready, result fields       | results out
//  cfg     | cfg_write, cfg_index, cfg_data           | limit writes
//
// One byte is taken per cycle while the queue has room; its results appear in the queue the next cycle.
// The rate is set by the four-entry result queue: input stalls when more
// than two entries are waiting, so an output stall reaches the input once
// three results are queued.
// Reset sets all limits to 255 and the parser to keyword scanning.
module http_request_header_extractor_top import hrx_pkg::*; #(
	parameter int MAX_FIELD = MAX_FIELD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  field_kind,
	output logic [7:0]  position,
	output logic [7:0]  char_value,
	output logic [1:0]  content_type,
	output logic [31:0] content_length,
	output logic        is_html,
	output logic        has_query,
	output logic [7:0]  query_pos,
	output logic [3:0]  seen_flags,
	output logic        ok,
	output logic        summary_last,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]    path_limit_q, host_limit_q, agent_limit_q;
	logic          accept;
	logic          byte_valid, sum_valid;
	result_t       byte_res, sum_res, dout;
	parse_status_t status;

	assign accept = in_valid && in_ready;

	// hold limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_limit_q <= 8'hFF;
			host_limit_q <= 8'hFF;
			agent_limit_q <= 8'hFF;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATH_LIMIT:  path_limit_q <= cfg_data;
				REG_HOST_LIMIT:  host_limit_q <= cfg_data;
				REG_AGENT_LIMIT: agent_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hrx_parser #(.MAX_FIELD(MAX_FIELD)) u_parser (
		.clk, .arst_n, .accept, .byte_value, .last_byte,
		.path_limit(path_limit_q), .host_limit(host_limit_q), .agent_limit(agent_limit_q),
		.byte_valid, .byte_res, .sum_valid, .sum_res, .status
	);

	hrx_out_queue u_queue (
		.clk, .arst_n,
		.wr0(accept && byte_valid), .din0(byte_res),
		.wr1(accept && sum_valid), .din1(sum_res),
		.room(in_ready), .out_valid, .out_ready, .dout
	);

	assign field_kind     = dout.field_kind;
	assign position       = dout.position;
	assign char_value     = dout.char_value;
	assign content_type   = dout.content_type;
	assign content_length = dout.content_length;
	assign is_html        = dout.is_html;
	assign has_query      = dout.has_query;
	assign query_pos      = dout.query_pos;
	assign seen_flags     = dout.seen_flags;
	assign ok             = dout.ok;
	assign summary_last   = dout.summary_last;

`ifndef ASSERT_OFF
	a_sum_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && summary_last |-> field_kind == KIND_SUMMARY)
		else $error("summary beat with wrong kind");
	a_last_rescan: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> status.phase == PH_SCAN && !status.failed)
		else $error("parser not reset after last byte");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty queue");
`endif

endmodule
